// File: hw/rtl/eacq_pkg.sv
// eacq_pkg: shared constants, types and rule helpers for the automaton cell query unit
// no dependencies; imported by eacq_ctrl, eacq_dp and the top level

package eacq_pkg;

  localparam int MAX_ROWS   = 32;
  localparam int ROW_W      = 63;
  localparam int CENTER     = 31;
  localparam int ROW_ADDR_W = $clog2(MAX_ROWS);
  localparam int ROWS_CNT_W = $clog2(MAX_ROWS + 1);

  localparam int COL_W      = 7;
  localparam int GEN_W      = 6;
  localparam int RULE_W     = 8;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic [RULE_W-1:0] RULE_RESET = 8'd30;
  localparam logic [ROW_W-1:0]  SEED_ROW   = {{(ROW_W-1){1'b0}}, 1'b1} << CENTER;
  localparam logic [COL_W-1:0]  CENTER_OFS = COL_W'(CENTER);

  typedef struct packed {
    logic capture;
    logic cfg_write;
    logic build;
    logic rd;
    logic take_direct;
    logic take_ram;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic direct;
    logic need_build;
    logic out_free;
  } stat_t;

  // background of the row after one with background bg
  function automatic logic next_bg(input logic bg, input logic [RULE_W-1:0] rule);
    next_bg = bg ? rule[7] : rule[0];
  endfunction

  // background of generation gen, closed form of the background recurrence
  function automatic logic bg_of(input logic [RULE_W-1:0] rule, input logic [GEN_W-1:0] gen);
    if (gen == '0) begin
      bg_of = 1'b0;
    end else if (!rule[0]) begin
      bg_of = 1'b0;
    end else if (rule[7]) begin
      bg_of = 1'b1;
    end else begin
      bg_of = gen[0];
    end
  endfunction

  // one generation step over the whole stored row, edges see the background
  function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] prev, input logic bg,
                                                input logic [RULE_W-1:0] rule);
    logic [ROW_W+1:0] ext;
    logic [ROW_W-1:0] res;
    ext = {bg, prev, bg};
    for (int p = 0; p < ROW_W; p++) begin
      res[p] = rule[{ext[p], ext[p+1], ext[p+2]}];
    end
    next_row = res;
  endfunction

endpackage

// File: hw/rtl/eacq_ram.sv
// eacq_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module eacq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/eacq_ctrl.sv
// eacq_ctrl: sequencer for the automaton cell query unit
// depends on eacq_pkg; drives the datapath through cmd_t, watches stat_t

module eacq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  eacq_pkg::stat_t status,
  output eacq_pkg::cmd_t  cmd
);

  import eacq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_RDATA = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_ready   = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.cfg_write = cfg_valid;
        cmd.capture   = s_valid;
        if (s_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.direct) begin
          cmd.take_direct = 1'b1;
          state_next      = ST_DONE;
        end else if (status.need_build) begin
          cmd.build = 1'b1;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_RDATA;
        end
      end
      ST_RDATA: begin
        cmd.take_ram = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/eacq_dp.sv
// eacq_dp: datapath of the automaton cell query unit: rule, row builder, row store, output
// depends on eacq_pkg and eacq_ram

module eacq_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  eacq_pkg::cmd_t                        cmd,
  output eacq_pkg::stat_t                       status,
  input  logic [eacq_pkg::IN_TDATA_W-1:0]       in_data,
  input  logic [eacq_pkg::RULE_W-1:0]           cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [eacq_pkg::OUT_TDATA_W-1:0]      out_data
);

  import eacq_pkg::*;

  logic [RULE_W-1:0]     rule;
  logic [ROW_W-1:0]      prev_row;
  logic                  last_bg;
  logic [ROWS_CNT_W-1:0] rows_built;
  logic [COL_W-1:0]      q_col;
  logic [GEN_W-1:0]      q_gen;
  logic                  res;
  logic                  out_bit;

  logic [ROW_W-1:0]      new_row;
  logic [ROW_W-1:0]      rd_row;
  logic [COL_W-1:0]      abs_col;
  logic [COL_W-1:0]      bit_idx;
  logic                  gen_neg;
  logic                  outside;
  logic                  too_big;
  logic                  direct_val;

  assign new_row = next_row(prev_row, last_bg, rule);

  // rule register and build state, a rule write restarts from the seed row
  always_ff @(posedge clk) begin
    if (rst) begin
      rule       <= RULE_RESET;
      prev_row   <= SEED_ROW;
      last_bg    <= 1'b0;
      rows_built <= ROWS_CNT_W'(1);
    end else if (cmd.cfg_write) begin
      rule       <= cfg_data;
      prev_row   <= SEED_ROW;
      last_bg    <= 1'b0;
      rows_built <= ROWS_CNT_W'(1);
    end else if (cmd.build) begin
      prev_row   <= new_row;
      last_bg    <= next_bg(last_bg, rule);
      rows_built <= rows_built + ROWS_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_col <= in_data[COL_W-1:0];
      q_gen <= in_data[COL_W +: GEN_W];
    end
  end

  // row 0 never goes to the store, queries on it are answered directly
  eacq_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_ROWS)
  ) u_rows (
    .clk  (clk),
    .we   (cmd.build),
    .waddr(rows_built[ROW_ADDR_W-1:0]),
    .wdata(new_row),
    .re   (cmd.rd),
    .raddr(q_gen[ROW_ADDR_W-1:0]),
    .rdata(rd_row)
  );

  always_comb begin
    gen_neg = q_gen[GEN_W-1];
    abs_col = q_col[COL_W-1] ? (~q_col + COL_W'(1)) : q_col;
    outside = abs_col > COL_W'(q_gen);
    too_big = 32'(q_gen) >= 32'(MAX_ROWS);
    bit_idx = q_col + CENTER_OFS;
    if (gen_neg) begin
      direct_val = 1'b0;
    end else if (outside) begin
      direct_val = bg_of(rule, q_gen);
    end else if (too_big) begin
      direct_val = 1'b0;
    end else begin
      direct_val = 1'b1;
    end
    status.direct     = gen_neg || outside || too_big || (q_gen == '0);
    status.need_build = 32'(rows_built) <= 32'(q_gen);
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_direct) begin
      res <= direct_val;
    end else if (cmd.take_ram) begin
      res <= rd_row[bit_idx[5:0]];
    end
  end

  // output register, decouples the result from the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_bit <= res;
    end
  end

  assign out_data = {{(OUT_TDATA_W-1){1'b0}}, out_bit};

`ifndef SYNTH
  a_rows_range: assert property (@(posedge clk) disable iff (rst)
    (rows_built != '0) && (32'(rows_built) <= 32'(MAX_ROWS)))
    else $error("rows_built out of range");

  a_build_step: assert property (@(posedge clk) disable iff (rst)
    cmd.build |=> (rows_built == $past(rows_built) + ROWS_CNT_W'(1)))
    else $error("row build did not advance rows_built");

  a_build_needed: assert property (@(posedge clk) disable iff (rst)
    cmd.build |-> (!status.direct && status.need_build))
    else $error("row built without need");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken result");
`endif

endmodule

// File: hw/rtl/elementary_automaton_cell_query_unit.sv
// elementary_automaton_cell_query_unit: top level of the automaton cell query unit
// depends on eacq_pkg, eacq_ctrl, eacq_dp (which holds eacq_ram)
//
// usage:
// - s_axis carries one request: column (7 bit signed) and generation (6 bit signed)
// - m_axis returns the queried cell value, one result per request, in order
// - cfg carries a new rule number; writing it drops all built rows back to the
//   seed row; write it only while no request is in flight
// - rows are built on demand, one full 63-cell row per cycle by the rule stepper,
//   and written into a 32-row store with a registered read port
// - negative generations, cells outside the light cone and generation 0 are answered
//   directly; any other request first builds the k rows still missing (0 to 31)
//   by the row stepper loop, then reads its row from the store
// - a new request is taken once the previous one has moved its result into the
//   output register, so no new request is taken while one is being processed
// - a finished result waits in the output register while m_axis_tready is low;
//   the next request is still taken and processed meanwhile, stalling only when
//   its own result is ready and the register is still full
// - reset: rule 30, only the seed row built, no result pending; no clearing pass

module elementary_automaton_cell_query_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // request: [6:0] column, [12:7] generation, [15:13] zero
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [eacq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // result: [0] cell_value, [7:1] zero
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [eacq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // rule number write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [eacq_pkg::RULE_W-1:0]          cfg_data
);

  import eacq_pkg::*;

  cmd_t  cmd;
  stat_t status;

  // sequencer: decides direct answer, row builds, store read and output load
  eacq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: rule register, row stepper, row store and output register
  eacq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_axis_tdata),
    .cfg_data (cfg_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata)
  );

endmodule
